@@ hdl/dmes_pkg.sv @@
// ----------------------------------------------------------------------------
// dmes_pkg
// shared types, codes and constants of the delayed midi event scheduler
// ----------------------------------------------------------------------------
package dmes_pkg;

   // default number of event slots
   localparam int SLOTS_DEFAULT = 32;

   // depth of the command queue between front and back
   localparam int QDEPTH = 2;

   // stream widths
   localparam int REQ_TDATA_W = 96;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 2;

   // midi constants
   localparam logic [7:0] MAX_CHANNEL   = 8'd16;
   localparam logic [7:0] ALL_NOTES_OFF = 8'd123;

   // request function codes
   localparam logic [1:0] FUNC_SCHED = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // event kinds
   localparam logic [1:0] EV_NOTE_ON  = 2'd0;
   localparam logic [1:0] EV_NOTE_OFF = 2'd1;
   localparam logic [1:0] EV_CTRL     = 2'd2;
   localparam logic [1:0] EV_STOP_ALL = 2'd3;

   // result kinds
   localparam logic [1:0] RK_ACK      = 2'd0;
   localparam logic [1:0] RK_NOTE_ON  = 2'd1;
   localparam logic [1:0] RK_NOTE_OFF = 2'd2;
   localparam logic [1:0] RK_CTRL     = 2'd3;

   // acknowledge status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_BADCH = 2'd2;

   // classified operation carried from front to back
   typedef enum logic [1:0] {
      OP_SCHED,
      OP_BADCH,
      OP_TICK,
      OP_CLEAR
   } op_type;

   // back sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_ACK,
      S_SCAN,
      S_EVAL,
      S_FLUSH
   } state_type;

   // queued command; stamp is the due time for a schedule, now for a tick
   typedef struct packed {
      op_type      op;
      logic [1:0]  kind;
      logic [4:0]  channel;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [31:0] stamp;
   } cmd_type;

   // one stored slot
   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  channel;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [31:0] due;
   } slot_type;

   // one result item
   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] status;
      logic [4:0] channel;
      logic [7:0] first;
      logic [7:0] second;
      logic       last;
   } rsp_type;

   // queue handshake between front and back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qout_type;

endpackage

@@ hdl/dmes_ram.sv @@
// ----------------------------------------------------------------------------
// dmes_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dmes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dmes_front.sv @@
// ----------------------------------------------------------------------------
// dmes_front
// unpacks request transfers, checks the channel and computes due times
// ----------------------------------------------------------------------------
module dmes_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dmes_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [dmes_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                 q_full,
   output logic                                 q_push,
   output dmes_pkg::cmd_type                    q_cmd
);
   import dmes_pkg::*;

   logic [1:0]  kind;
   logic [7:0]  channel;
   logic [7:0]  first;
   logic [7:0]  second;
   logic [31:0] delay;
   logic [31:0] now;
   logic        bad_ch;
   logic        take;

   assign kind    = req_tdata[1:0];
   assign channel = req_tdata[9:2];
   assign first   = req_tdata[17:10];
   assign second  = req_tdata[25:18];
   assign delay   = req_tdata[57:26];
   assign now     = req_tdata[89:58];

   assign req_tready = !q_full;
   assign take       = req_tvalid && !q_full;
   assign bad_ch     = (channel == 8'd0) || (channel > MAX_CHANNEL);

   always_comb begin
      q_push         = 1'b0;
      q_cmd.op       = OP_TICK;
      q_cmd.kind     = kind;
      q_cmd.channel  = channel[4:0];
      q_cmd.first    = first;
      q_cmd.second   = second;
      q_cmd.stamp    = now;
      unique case (req_tuser)
         FUNC_SCHED: begin
            q_push      = take;
            q_cmd.op    = bad_ch ? OP_BADCH : OP_SCHED;
            q_cmd.stamp = now + delay;
         end
         FUNC_TICK: begin
            q_push   = take;
            q_cmd.op = OP_TICK;
         end
         FUNC_CLEAR: begin
            q_push   = take;
            q_cmd.op = OP_CLEAR;
         end
         default: begin
            // unused function, accepted and dropped
            q_push = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/dmes_queue.sv @@
// ----------------------------------------------------------------------------
// dmes_queue
// short command queue that decouples the front from the back
// ----------------------------------------------------------------------------
module dmes_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dmes_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output dmes_pkg::qout_type head
);
   import dmes_pkg::*;

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   cmd_type          entry_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(QDEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

@@ hdl/dmes_back.sv @@
// ----------------------------------------------------------------------------
// dmes_back
// slot table sequencer: stores events, scans for due slots, drives results
// ----------------------------------------------------------------------------
module dmes_back #(
   parameter int SLOTS = dmes_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  dmes_pkg::qout_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dmes_pkg::rsp_type  rsp
);
   import dmes_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SLOTS-1:0] active_ff, active_in;
   cmd_type          cmd_ff, cmd_in;
   rsp_type          pend_ff, pend_in;
   logic             have_pend_ff, have_pend_in;
   logic [1:0]       ack_ff, ack_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             load;
   rsp_type          load_data;
   logic             out_free;
   logic             idx_last;
   logic             wr_en;
   slot_type         wr_slot;
   logic [$bits(slot_type)-1:0] rd_word;
   slot_type         rd_slot;
   rsp_type          msg;
   logic             due_hit;

   dmes_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_slot),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   assign rd_slot  = slot_type'(rd_word);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_last = (idx_ff == IDX_W'(SLOTS - 1));
   assign due_hit  = (rd_slot.due <= cmd_ff.stamp);

   always_comb begin
      wr_slot.kind    = cmd_ff.kind;
      wr_slot.channel = cmd_ff.channel;
      wr_slot.first   = cmd_ff.first;
      wr_slot.second  = cmd_ff.second;
      wr_slot.due     = cmd_ff.stamp;
   end

   // message for the slot being read
   always_comb begin
      msg.status  = ST_OK;
      msg.channel = rd_slot.channel;
      msg.first   = rd_slot.first;
      msg.second  = rd_slot.second;
      msg.last    = 1'b0;
      unique case (rd_slot.kind)
         EV_NOTE_ON: begin
            msg.kind = RK_NOTE_ON;
         end
         EV_NOTE_OFF: begin
            msg.kind   = RK_NOTE_OFF;
            msg.second = 8'd0;
         end
         EV_CTRL: begin
            msg.kind = RK_CTRL;
         end
         default: begin
            msg.kind   = RK_CTRL;
            msg.first  = ALL_NOTES_OFF;
            msg.second = 8'd0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      cmd_in       = cmd_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      ack_in       = ack_ff;
      pop          = 1'b0;
      load         = 1'b0;
      load_data    = pend_ff;
      wr_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop          = 1'b1;
               cmd_in       = head.cmd;
               idx_in       = '0;
               have_pend_in = 1'b0;
               unique case (head.cmd.op)
                  OP_SCHED: begin
                     state_in = S_FIND;
                  end
                  OP_BADCH: begin
                     ack_in   = ST_BADCH;
                     state_in = S_ACK;
                  end
                  OP_TICK: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     active_in = '0;
                     ack_in    = ST_OK;
                     state_in  = S_ACK;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (!active_ff[idx_ff]) begin
               wr_en             = 1'b1;
               active_in[idx_ff] = 1'b1;
               ack_in            = ST_OK;
               state_in          = S_ACK;
            end else if (idx_last) begin
               ack_in   = ST_FULL;
               state_in = S_ACK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ACK: begin
            if (out_free) begin
               load             = 1'b1;
               load_data.kind    = RK_ACK;
               load_data.status  = ack_ff;
               load_data.channel = '0;
               load_data.first   = '0;
               load_data.second  = '0;
               load_data.last    = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_SCAN: begin
            if (active_ff[idx_ff]) begin
               state_in = S_EVAL;
            end else if (idx_last) begin
               state_in = S_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_EVAL: begin
            // a due slot pushes out the message held from the previous hit
            if (!(due_hit && have_pend_ff && !out_free)) begin
               if (due_hit) begin
                  load              = have_pend_ff;
                  pend_in           = msg;
                  have_pend_in      = 1'b1;
                  active_in[idx_ff] = 1'b0;
               end
               if (idx_last) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_FLUSH: begin
            if (!have_pend_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               load           = 1'b1;
               load_data.last = 1'b1;
               have_pend_in   = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         have_pend_ff <= have_pend_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cmd_ff  <= cmd_in;
      pend_ff <= pend_in;
      ack_ff  <= ack_in;
      if (load) begin
         rsp_ff <= load_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // clear frees every slot
   a_clear_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && head.valid && head.cmd.op == OP_CLEAR) |=> active_ff == '0)
      else $error("clear left an active slot");

   // a found free slot becomes active
   a_find_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND && !active_ff[idx_ff]) |=> active_ff[$past(idx_ff)])
      else $error("scheduled slot not marked active");

   // a dispatched slot is freed
   a_eval_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && due_hit && !(have_pend_ff && !out_free))
      |=> !active_ff[$past(idx_ff)])
      else $error("dispatched slot still active");

   // a held message is never dropped at the end of a tick
   a_flush_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && have_pend_ff && !out_free) |=> state_ff == S_FLUSH)
      else $error("pending message dropped");

endmodule

@@ hdl/delayed_midi_event_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// delayed_midi_event_scheduler_core
// holds delayed midi events in a slot table and dispatches them on ticks
// ----------------------------------------------------------------------------
// order: a clear or bad-channel acknowledge passes the queue, S_IDLE and S_ACK;
//   a schedule acknowledge also passes S_FIND up to the lowest free slot
// throughput: one command at a time in the back sequencer, which walks the slot
//   table one inactive slot per cycle through a single ram read port; an active
//   slot also passes S_EVAL, which can hold while the result register is busy
// reset: synchronous, clears the queue, all slot active bits and the output
// ----------------------------------------------------------------------------
module delayed_midi_event_scheduler_core #(
   parameter int SLOTS = dmes_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // event_kind[1:0], channel[9:2], first_data[17:10], second_data[25:18],
   // delay[57:26], now[89:58], zero fill above
   input  logic [dmes_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [dmes_pkg::REQ_TUSER_W-1:0] req_tuser,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], out_channel[6:2], out_first[14:7], out_second[22:15],
   // zero fill above
   output logic [dmes_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // result_kind[1:0]
   output logic [dmes_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast
);
   import dmes_pkg::*;

   // front to queue
   logic     q_push;
   cmd_type  q_cmd;
   logic     q_full;
   // queue to back
   qout_type q_head;
   logic     q_pop;
   // back output register
   rsp_type  rsp;

   // front: classify the request and compute the due time
   dmes_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   // short queue so the front keeps taking transfers while the back scans
   dmes_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   // back: slot table, scan sequencer and result register
   dmes_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the result fields onto the stream
   assign rsp_tdata = {1'b0, rsp.second, rsp.first, rsp.channel, rsp.status};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule
